// File: sv/occc_pkg.sv
// Package for the optical color centroid classifier.
// Holds the widths, constants and the sequencer state type. No dependencies.
package occc_pkg;
   localparam int NUM_CLASSES = 8;
   localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam logic [31:0] COND_SCALE = 32'd1000000000;
   localparam logic [31:0] SHIFT_LIMIT = 32'd4000000;
   localparam logic [9:0] NORM_TOTAL = 10'd1000;
   localparam logic [31:0] ALL_ONES = 32'hFFFFFFFF;
   localparam logic CSR_MIN_SIGNAL = 1'b0;
   localparam logic CSR_MATCH_THRESHOLD = 1'b1;
   localparam logic ACT_MEASURE = 1'b0;
   localparam logic ACT_LOAD = 1'b1;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_DIV   = 10'b0000000010,
      ST_SUM   = 10'b0000000100,
      ST_SHIFT = 10'b0000001000,
      ST_NORM  = 10'b0000010000,
      ST_SCAN  = 10'b0000100000,
      ST_SQRT  = 10'b0001000000,
      ST_OUT   = 10'b0010000000,
      ST_LOW   = 10'b0100000000,
      ST_NDIV  = 10'b1000000000
   } state_type;
endpackage

// File: sv/occc_req_if.sv
// Input and result channel interfaces.
// Depends on nothing.
interface occc_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [31:0] dark_time;
   logic [31:0] red_time;
   logic [31:0] green_time;
   logic [31:0] blue_time;
   logic [2:0]  entry_index;
   logic [9:0]  entry_red;
   logic [9:0]  entry_green;
   logic [9:0]  entry_blue;
   modport source (output valid, action, dark_time, red_time, green_time, blue_time,
                   entry_index, entry_red, entry_green, entry_blue, input ready);
   modport sink (input valid, action, dark_time, red_time, green_time, blue_time,
                 entry_index, entry_red, entry_green, entry_blue, output ready);
endinterface

interface occc_rsp_if;
   logic              valid;
   logic              ready;
   logic [9:0]        share_red;
   logic [9:0]        share_green;
   logic [9:0]        share_blue;
   logic              signal_status;
   logic signed [3:0] class_index;
   logic [31:0]       distance_squared;
   logic [10:0]       distance;
   modport source (output valid, share_red, share_green, share_blue, signal_status,
                   class_index, distance_squared, distance, input ready);
   modport sink (input valid, share_red, share_green, share_blue, signal_status,
                 class_index, distance_squared, distance, output ready);
endinterface

// File: sv/occc_div.sv
// Shared restoring divider, one quotient bit per cycle, 64 by 32 bits.
// Depends on occc_pkg.
module occc_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   import occc_pkg::*;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] q_ff, q_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic        busy_ff, busy_in;
   logic [32:0] trial;

   always_comb begin
      cnt_in = cnt_ff; q_in = q_ff; rem_in = rem_ff; dvs_in = dvs_ff;
      busy_in = busy_ff;
      trial = {rem_ff[31:0], q_ff[63]};
      if (start) begin
         q_in = dividend; rem_in = '0; dvs_in = divisor; cnt_in = 7'd64; busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in = {q_ff[62:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            q_in[0] = 1'b1;
         end else begin
            rem_in = trial;
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in; rem_ff <= rem_in; dvs_ff <= dvs_in;
   end

   assign done = busy_ff && (cnt_ff == 7'd1);
   assign quotient = {q_ff[62:0], (trial >= {1'b0, dvs_ff})};

   assert property (@(posedge clock) disable iff (reset) start |=> busy_ff)
      else $error("divider did not start");
   assert property (@(posedge clock) disable iff (reset) done |=> !busy_ff)
      else $error("divider still busy after done");
   assert property (@(posedge clock) disable iff (reset) !busy_ff |-> !done)
      else $error("done while idle");
endmodule

// File: sv/occc_sqrt.sv
// Bit-pair integer square root, one step per cycle over 16 steps.
// Depends on occc_pkg.
module occc_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] value,
   output logic        done,
   output logic [15:0] root
);
   import occc_pkg::*;
   logic [31:0] v_ff, v_in, r_ff, r_in, b_ff, b_in;
   logic        busy_ff, busy_in;

   always_comb begin
      v_in = v_ff; r_in = r_ff; b_in = b_ff; busy_in = busy_ff;
      if (start) begin
         v_in = value; r_in = '0; b_in = 32'h40000000; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (v_ff >= r_ff + b_ff) begin
            v_in = v_ff - (r_ff + b_ff);
            r_in = (r_ff >> 1) + b_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         b_in = b_ff >> 2;
         if (b_ff == 32'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
      v_ff <= v_in; r_ff <= r_in; b_ff <= b_in;
   end

   assign done = busy_ff && (b_ff == 32'd1);
   assign root = r_in[15:0];

   assert property (@(posedge clock) disable iff (reset) done |=> !busy_ff)
      else $error("sqrt still busy after done");
   assert property (@(posedge clock) disable iff (reset) start |=> busy_ff)
      else $error("sqrt did not start");
   assert property (@(posedge clock) disable iff (reset) busy_ff |-> $onehot(b_ff))
      else $error("sqrt bit not one-hot");
endmodule

// File: sv/optical_color_centroid_classifier.sv
// Top level of the optical color centroid classifier.
// Depends on occc_pkg, occc_req_if/occc_rsp_if, occc_div and occc_sqrt.
//
// Use:
//  - req channel: action 1 loads centroid slot entry_index (no result);
//    action 0 measures four discharge times and yields one rsp item.
//  - csr port: index 0 min_signal (reset 1000), 1 match_threshold (reset 0).
//    Write only while idle.
//  - One item at a time; req.ready is high only in idle.
//  - A load is written at the accepting edge and the block stays idle. After
//    a measure is accepted: the 4 conductance divides, a sum step, the shift
//    steps (at most 10 halvings plus a check), the 3 share divides, a scan of
//    the 8 table entries and the root, then rsp.valid rises. All divides use
//    the one shared bit-serial divider.
//  - Low signal skips the shares, scan and root.
//  - The next item is taken the cycle after the result handshake.
//  - The result stays in the output register until rsp.ready; a stalled
//    receiver holds the block in its output state.
//  - Reset (synchronous) returns to idle and restores the csr registers;
//    the centroid table is not cleared and must be loaded before measures.
module optical_color_centroid_classifier (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic              csr_index,
   input  logic [31:0]       csr_write_data,
   occc_req_if.sink          req,
   occc_rsp_if.source        rsp
);
   import occc_pkg::*;

   state_type   state_ff, state_in;
   logic [31:0] min_signal_ff, match_threshold_ff;
   logic [29:0] table_mem [NUM_CLASSES];
   logic [31:0] times_ff [4];
   logic [31:0] cond_ff [4];
   logic [33:0] sum_ff;
   logic [1:0]  k_ff;
   logic [CLS_W:0] c_ff;
   logic [9:0]  share_ff [3];
   logic [31:0] best_ff;
   logic [CLS_W-1:0] best_c_ff;
   logic [10:0] dist_ff;
   logic        low_ff;

   logic        div_start, div_done, sq_start, sq_done;
   logic [63:0] div_dividend, div_q;
   logic [31:0] div_divisor;
   logic [15:0] sq_root;

   occc_div u_div (.clock, .reset, .start(div_start), .dividend(div_dividend),
                   .divisor(div_divisor), .done(div_done), .quotient(div_q));
   occc_sqrt u_sqrt (.clock, .reset, .start(sq_start), .value(best_ff),
                     .done(sq_done), .root(sq_root));

   logic started_ff;
   logic [31:0] v0, v1, v2;
   logic [33:0] vsum;
   logic [29:0] ent_ff;
   logic [CLS_W-1:0] c_nx;
   logic [10:0] d0, d1, d2;
   logic [31:0] dsum;

   assign req.ready = (state_ff == ST_IDLE);
   // table entry for the next scan step is fetched into ent_ff during the previous scan step
   assign c_nx = c_ff[CLS_W-1:0] + CLS_W'(1);

   always_comb begin
      // corrected values from conductances
      v0 = (cond_ff[1] > cond_ff[0]) ? cond_ff[1] - cond_ff[0] : '0;
      v1 = (cond_ff[2] > cond_ff[0]) ? cond_ff[2] - cond_ff[0] : '0;
      v2 = (cond_ff[3] > cond_ff[0]) ? cond_ff[3] - cond_ff[0] : '0;
      vsum = 34'(v0) + 34'(v1) + 34'(v2);
      d0 = (share_ff[0] > ent_ff[29:20]) ? {1'b0, share_ff[0]} - {1'b0, ent_ff[29:20]}
                                         : {1'b0, ent_ff[29:20]} - {1'b0, share_ff[0]};
      d1 = (share_ff[1] > ent_ff[19:10]) ? {1'b0, share_ff[1]} - {1'b0, ent_ff[19:10]}
                                         : {1'b0, ent_ff[19:10]} - {1'b0, share_ff[1]};
      d2 = (share_ff[2] > ent_ff[9:0]) ? {1'b0, share_ff[2]} - {1'b0, ent_ff[9:0]}
                                       : {1'b0, ent_ff[9:0]} - {1'b0, share_ff[2]};
      dsum = 32'(d0) * 32'(d0) + 32'(d1) * 32'(d1) + 32'(d2) * 32'(d2);
   end

   // divider operand select: conductance phase divides scale by time,
   // share phase divides value*1000 by sum (cond_ff holds shifted values)
   always_comb begin
      div_start = (state_ff == ST_DIV || state_ff == ST_NDIV) && !started_ff;
      if (state_ff == ST_DIV) begin
         div_dividend = {32'd0, COND_SCALE};
         div_divisor  = times_ff[k_ff];
      end else begin
         div_dividend = 64'(cond_ff[k_ff + 2'd1]) * 64'(NORM_TOTAL);
         div_divisor  = sum_ff[31:0];
      end
      sq_start = (state_ff == ST_SQRT) && !started_ff;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req.valid && req.action == ACT_MEASURE) state_in = ST_DIV;
         ST_DIV:   if (div_done && k_ff == 2'd3) state_in = ST_SUM;
         ST_SUM:   state_in = (vsum >= 34'(min_signal_ff)) ? ST_SHIFT : ST_LOW;
         ST_SHIFT: if (sum_ff <= 34'(SHIFT_LIMIT))
                      state_in = (sum_ff < 34'(min_signal_ff) || sum_ff == '0) ? ST_LOW
                                                                               : ST_NDIV;
         ST_NDIV:  if (div_done && k_ff == 2'd2) state_in = ST_SCAN;
         ST_SCAN:  if (c_ff == (CLS_W+1)'(NUM_CLASSES - 1)) state_in = ST_SQRT;
         ST_SQRT:  if (sq_done) state_in = ST_OUT;
         ST_LOW:   state_in = ST_OUT;
         ST_OUT:   if (rsp.ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         min_signal_ff <= 32'd1000;
         match_threshold_ff <= '0;
         started_ff <= 1'b0;
         k_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            if (csr_index == CSR_MIN_SIGNAL) min_signal_ff <= csr_write_data;
            else match_threshold_ff <= csr_write_data;
         end
         started_ff <= (div_start || sq_start || started_ff) && !(div_done || sq_done)
                       && (state_in == state_ff);
         if (state_ff == ST_IDLE || state_ff == ST_SHIFT) k_ff <= '0;
         else if (div_done) k_ff <= k_ff + 2'd1;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req.valid) begin
         if (req.action == ACT_LOAD) begin
            if (32'(req.entry_index) < 32'(NUM_CLASSES))
               table_mem[req.entry_index[CLS_W-1:0]] <=
                  {req.entry_red, req.entry_green, req.entry_blue};
         end
         times_ff[0] <= req.dark_time; times_ff[1] <= req.red_time;
         times_ff[2] <= req.green_time; times_ff[3] <= req.blue_time;
      end
      if (state_ff == ST_DIV && div_done)
         cond_ff[k_ff] <= (times_ff[k_ff] == '0) ? '0 : div_q[31:0];
      if (state_ff == ST_SUM) begin
         cond_ff[1] <= v0; cond_ff[2] <= v1; cond_ff[3] <= v2;
         sum_ff <= vsum;
      end
      if (state_ff == ST_SHIFT && sum_ff > 34'(SHIFT_LIMIT)) begin
         cond_ff[1] <= cond_ff[1] >> 1; cond_ff[2] <= cond_ff[2] >> 1;
         cond_ff[3] <= cond_ff[3] >> 1;
         sum_ff <= 34'(cond_ff[1] >> 1) + 34'(cond_ff[2] >> 1) + 34'(cond_ff[3] >> 1);
      end
      if (state_ff == ST_NDIV && div_done) share_ff[k_ff] <= div_q[9:0];
      if (state_ff == ST_NDIV) begin
         c_ff <= '0; best_ff <= ALL_ONES; best_c_ff <= '0;
         ent_ff <= table_mem[CLS_W'(0)];
      end
      if (state_ff == ST_SCAN) begin
         c_ff <= c_ff + 1'b1;
         ent_ff <= table_mem[c_nx];
         if (dsum < best_ff) begin
            best_ff <= dsum; best_c_ff <= c_ff[CLS_W-1:0];
         end
      end
      if (state_ff == ST_SQRT && sq_done) dist_ff <= sq_root[10:0];
      if (state_ff == ST_LOW) low_ff <= 1'b1;
      else if (state_ff == ST_SUM || state_ff == ST_SHIFT) low_ff <= 1'b0;
   end

   assign rsp.valid = (state_ff == ST_OUT);
   assign rsp.signal_status = low_ff;
   assign rsp.share_red   = low_ff ? '0 : share_ff[0];
   assign rsp.share_green = low_ff ? '0 : share_ff[1];
   assign rsp.share_blue  = low_ff ? '0 : share_ff[2];
   assign rsp.distance_squared = low_ff ? ALL_ONES : best_ff;
   assign rsp.distance = low_ff ? '0 : dist_ff;
   assign rsp.class_index = (!low_ff && best_ff <= match_threshold_ff)
                            ? 4'(best_c_ff) : 4'sb1111;

   assert property (@(posedge clock) disable iff (reset)
                    rsp.valid && !rsp.ready |=> rsp.valid)
      else $error("result dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
                    req.ready |-> !rsp.valid)
      else $error("ready while a result waits");
   assert property (@(posedge clock) disable iff (reset)
                    state_ff == ST_SCAN |-> c_ff < (CLS_W+1)'(NUM_CLASSES))
      else $error("scan index out of range");
endmodule

// File: tb/tb_top.sv
// Testbench for optical_color_centroid_classifier: queue-fed driver, monitor, predictor.
// Depends on occc_pkg, occc_req_if/occc_rsp_if and the classifier RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import occc_pkg::*;

   localparam int HOLD_OFF_CYCLES = 650;         // covers one full measure
   localparam longint TIMEOUT_NS = 64'd60000000;

   typedef struct {
      logic        action;
      logic [31:0] dark_t, red_t, green_t, blue_t;
      logic [2:0]  slot;
      logic [9:0]  c_red, c_green, c_blue;
   } occc_item_type;

   typedef struct {
      logic [9:0]        s_red, s_green, s_blue;
      logic              low_sig;
      logic signed [3:0] cls;
      logic [31:0]       dist_sq;
      logic [10:0]       dist_root;
   } occc_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = CSR_MIN_SIGNAL;
   logic [31:0] csr_write_data = '0;

   occc_req_if req_ch();
   occc_rsp_if rsp_ch();

   optical_color_centroid_classifier uut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req(req_ch), .rsp(rsp_ch)
   );

   // predictor state: register mirror and centroid table copy
   logic [31:0] min_signal_m = 32'd1000;
   logic [31:0] threshold_m = 32'd0;
   logic [9:0]  centroid_m [NUM_CLASSES][3];

   occc_item_type   pending_items[$];
   occc_result_type expected_results[$];
   int              error_count = 0;

   // sender and receiver pacing
   bit sender_pause = 1'b0;
   int burst_left = 0;
   int gap_left = 0;
   int rsp_hold_cycles = 0;
   int stall_left = 0;
   int calm_left = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.action = ACT_MEASURE;
      req_ch.dark_time = '0;
      req_ch.red_time = '0;
      req_ch.green_time = '0;
      req_ch.blue_time = '0;
      req_ch.entry_index = '0;
      req_ch.entry_red = '0;
      req_ch.entry_green = '0;
      req_ch.entry_blue = '0;
      rsp_ch.ready = 1'b0;
   end

   function automatic logic [31:0] conductance(logic [31:0] t);
      if (t == 0) return 32'd0;
      return 32'd1000000000 / t;
   endfunction

   function automatic logic [10:0] int_root(logic [31:0] v);
      logic [15:0] r;
      logic [15:0] trial;
      r = '0;
      for (int b = 15; b >= 0; b--) begin
         trial = r | (16'd1 << b);
         if (64'(trial) * 64'(trial) <= 64'(v)) r = trial;
      end
      return r[10:0];
   endfunction

   // Applies one accepted item: loads update the table, measures queue a result.
   function automatic void classify_item(occc_item_type it);
      logic [31:0] g_dark, g;
      logic [31:0] val[3];
      logic [63:0] sum;
      logic [31:0] shr[3];
      logic [31:0] best, d2, d;
      int          best_c;
      occc_result_type res;
      if (it.action == ACT_LOAD) begin
         centroid_m[it.slot][0] = it.c_red;
         centroid_m[it.slot][1] = it.c_green;
         centroid_m[it.slot][2] = it.c_blue;
         return;
      end
      g_dark = conductance(it.dark_t);
      sum = '0;
      for (int k = 0; k < 3; k++) begin
         g = conductance(k == 0 ? it.red_t : (k == 1 ? it.green_t : it.blue_t));
         val[k] = (g > g_dark) ? g - g_dark : 32'd0;
         sum += val[k];
      end
      if (sum >= min_signal_m) begin
         while (sum > 64'd4000000) begin
            sum = '0;
            for (int k = 0; k < 3; k++) begin
               val[k] = val[k] >> 1;
               sum += val[k];
            end
         end
      end
      if (sum < min_signal_m || sum == 0) begin
         res = '{s_red: '0, s_green: '0, s_blue: '0, low_sig: 1'b1,
                 cls: -4'sd1, dist_sq: 32'hFFFFFFFF, dist_root: '0};
      end else begin
         for (int k = 0; k < 3; k++) shr[k] = 32'((64'(val[k]) * 64'd1000) / sum);
         best = 32'hFFFFFFFF;
         best_c = 0;
         for (int c = 0; c < NUM_CLASSES; c++) begin
            d2 = '0;
            for (int k = 0; k < 3; k++) begin
               d = (shr[k] > centroid_m[c][k]) ? shr[k] - centroid_m[c][k]
                                                : centroid_m[c][k] - shr[k];
               d2 += d * d;
            end
            if (d2 < best) begin
               best = d2;
               best_c = c;
            end
         end
         res.s_red = shr[0][9:0];
         res.s_green = shr[1][9:0];
         res.s_blue = shr[2][9:0];
         res.low_sig = 1'b0;
         res.cls = (best <= threshold_m) ? 4'(best_c) : -4'sd1;
         res.dist_sq = best;
         res.dist_root = int_root(best);
      end
      expected_results.push_back(res);
   endfunction

   // Driver: bursts of items from the pending queue, random gaps between bursts.
   always @(posedge clock) begin
      occc_item_type it;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            it.action = req_ch.action;
            it.dark_t = req_ch.dark_time;
            it.red_t = req_ch.red_time;
            it.green_t = req_ch.green_time;
            it.blue_t = req_ch.blue_time;
            it.slot = req_ch.entry_index;
            it.c_red = req_ch.entry_red;
            it.c_green = req_ch.entry_green;
            it.c_blue = req_ch.entry_blue;
            classify_item(it);
         end
         // a held item stays put until the block takes it
         if (!(req_ch.valid && !req_ch.ready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (pending_items.size() > 0 && !sender_pause) begin
               it = pending_items.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.action <= it.action;
               req_ch.dark_time <= it.dark_t;
               req_ch.red_time <= it.red_t;
               req_ch.green_time <= it.green_t;
               req_ch.blue_time <= it.blue_t;
               req_ch.entry_index <= it.slot;
               req_ch.entry_red <= it.c_red;
               req_ch.entry_green <= it.c_green;
               req_ch.entry_blue <= it.c_blue;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 6);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 700);
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Monitor: receiver stall pattern, long hold-off, and result checking.
   always @(posedge clock) begin
      occc_result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               $display("unexpected result item at %0t", $realtime);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_ch.share_red !== want.s_red)
                  report_mismatch("share_red", rsp_ch.share_red, want.s_red);
               if (rsp_ch.share_green !== want.s_green)
                  report_mismatch("share_green", rsp_ch.share_green, want.s_green);
               if (rsp_ch.share_blue !== want.s_blue)
                  report_mismatch("share_blue", rsp_ch.share_blue, want.s_blue);
               if (rsp_ch.signal_status !== want.low_sig)
                  report_mismatch("signal_status", rsp_ch.signal_status, want.low_sig);
               if (rsp_ch.class_index !== want.cls)
                  report_mismatch("class_index", 32'(rsp_ch.class_index[3:0]),
                                  32'(want.cls[3:0]));
               if (rsp_ch.distance_squared !== want.dist_sq)
                  report_mismatch("distance_squared", rsp_ch.distance_squared, want.dist_sq);
               if (rsp_ch.distance !== want.dist_root)
                  report_mismatch("distance", rsp_ch.distance, want.dist_root);
            end
         end
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_ch.ready <= 1'b0;
         end else if (calm_left > 0) begin
            calm_left--;
            rsp_ch.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2: stall_left = $urandom_range(1, 8);
               3:       calm_left = $urandom_range(50, 1500);
               default: ;
            endcase
            rsp_ch.ready <= (stall_left == 0);
         end
      end
   end

   function automatic void queue_load(int slot, int r, int g, int b);
      occc_item_type it;
      it = '{action: ACT_LOAD, dark_t: $urandom, red_t: $urandom, green_t: $urandom,
             blue_t: $urandom, slot: 3'(slot), c_red: 10'(r), c_green: 10'(g),
             c_blue: 10'(b)};
      pending_items.push_back(it);
   endfunction

   function automatic void queue_measure(logic [31:0] dk, logic [31:0] r,
                                         logic [31:0] g, logic [31:0] b);
      occc_item_type it;
      it = '{action: ACT_MEASURE, dark_t: dk, red_t: r, green_t: g, blue_t: b,
             slot: 3'($urandom), c_red: 10'($urandom), c_green: 10'($urandom),
             c_blue: 10'($urandom)};
      pending_items.push_back(it);
   endfunction

   // Discharge time spread over every conductance regime, timeouts included.
   function automatic logic [31:0] pick_time();
      case ($urandom_range(0, 9))
         0:       return 32'd0;
         1:       return $urandom;
         2:       return $urandom_range(1, 100);
         3, 4:    return $urandom_range(100, 20000);
         5, 6, 7: return $urandom_range(20000, 2000000);
         default: return $urandom_range(2000000, 2000000000);
      endcase
   endfunction

   function automatic logic [31:0] pick_dark();
      case ($urandom_range(0, 5))
         0, 1:    return 32'd0;
         2:       return $urandom;
         3:       return $urandom_range(1, 20000);
         default: return $urandom_range(2000000, 32'hFFFFFFFF);
      endcase
   endfunction

   task automatic csr_write(logic idx, logic [31:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      if (idx == CSR_MIN_SIGNAL) min_signal_m = data;
      else threshold_m = data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic wait_idle();
      wait (pending_items.size() == 0 && !req_ch.valid && expected_results.size() == 0);
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
   endtask

   task automatic random_phase(int count, bit long_hold);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 12)
            queue_load($urandom_range(0, NUM_CLASSES - 1), $urandom_range(0, 1000),
                       $urandom_range(0, 1000), $urandom_range(0, 1000));
         else
            queue_measure(pick_dark(), pick_time(), pick_time(), pick_time());
      end
      // receiver goes quiet while the sender keeps offering: input stalls
      if (long_hold) rsp_hold_cycles = 3000;
      wait (pending_items.size() <= count / 2);
      // sender holds back until the block has drained
      sender_pause = 1'b1;
      wait (expected_results.size() == 0 && !req_ch.valid);
      sender_pause = 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      csr_write(CSR_MIN_SIGNAL, 32'd1000);
      csr_write(CSR_MATCH_THRESHOLD, 32'd0);

      // directed: fill the whole table first; slots 3 and 5 equal to force a tie
      queue_load(0, 1000, 0, 0);
      queue_load(1, 0, 1000, 0);
      queue_load(2, 0, 0, 1000);
      queue_load(3, 333, 333, 333);
      queue_load(4, 1023, 1023, 1023);
      queue_load(5, 333, 333, 333);
      queue_load(6, 500, 500, 0);
      queue_load(7, 0, 0, 0);
      queue_measure(32'd0, 32'd1, 32'd0, 32'd0);            // exact match, huge signal
      queue_measure(32'd0, 32'd0, 32'd1000, 32'd0);
      queue_measure(32'd0, 32'd3000, 32'd3000, 32'd3000);   // tie between equal slots
      queue_measure(32'd0, 32'd0, 32'd0, 32'd0);            // all timeouts: low signal
      queue_measure(32'd1, 32'd2, 32'd2, 32'd2);            // dark above colors
      queue_measure(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      queue_measure(32'd0, 32'd2000000, 32'd2000000, 32'd2000000); // just above min
      queue_measure(32'd0, 32'd3000000, 32'd3000000, 32'd3000000); // just below min
      queue_measure(32'd500000, 32'd1000, 32'd5000, 32'd1);
      queue_measure(32'd0, 32'd7, 32'd11, 32'd13);           // no match, near center
      wait_idle();

      csr_write(CSR_MIN_SIGNAL, 32'd0);
      csr_write(CSR_MATCH_THRESHOLD, 32'hFFFFFFFF);
      queue_measure(32'd0, 32'd0, 32'd0, 32'd0);             // zero sum still low
      queue_measure(32'd0, 32'd3000000000, 32'd0, 32'd0);
      random_phase(180, 1'b1);
      wait_idle();

      csr_write(CSR_MIN_SIGNAL, 32'hFFFFFFFF);
      csr_write(CSR_MATCH_THRESHOLD, 32'd5000);
      random_phase(60, 1'b0);
      wait_idle();

      csr_write(CSR_MIN_SIGNAL, 32'd1000);
      csr_write(CSR_MATCH_THRESHOLD, 32'd20000);
      random_phase(230, 1'b0);
      wait_idle();

      csr_write(CSR_MIN_SIGNAL, $urandom_range(0, 200000));
      csr_write(CSR_MATCH_THRESHOLD, $urandom);
      random_phase(260, 1'b1);
      wait_idle();

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

// File: filelist.f
sv/occc_pkg.sv
sv/occc_req_if.sv
sv/occc_div.sv
sv/occc_sqrt.sv
sv/optical_color_centroid_classifier.sv
tb/tb_top.sv
